@@ sv/sliding_window_linear_regression_top_assert.svh @@
// assertion macros for the sliding window regression top level
`ifndef SLIDING_WINDOW_LINEAR_REGRESSION_TOP_ASSERT_SVH
`define SLIDING_WINDOW_LINEAR_REGRESSION_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SWLR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SWLR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/swlr_pkg.sv @@
// shared types, constants and helpers for the sliding window regression
package swlr_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int IN_W            = 24;
    localparam int OUT_W           = 48;
    localparam int WS_W            = 7;
    localparam int WIDE            = 96;
    localparam int DIGIT_W         = 8;
    localparam int SLOPE_FRAC      = 24;

    localparam logic [WS_W-1:0] WINDOW_RESET = 7'd64;

    // item kinds
    localparam logic [2:0] KIND_ADD      = 3'd0;
    localparam logic [2:0] KIND_CLEAR    = 3'd1;
    localparam logic [2:0] KIND_FORECAST = 3'd2;
    localparam logic [2:0] KIND_REVERSE  = 3'd3;
    localparam logic [2:0] KIND_FIT      = 3'd4;

    // status codes
    localparam logic [1:0] STATUS_FIT   = 2'd0;
    localparam logic [1:0] STATUS_NOFIT = 2'd1;
    localparam logic [1:0] STATUS_FLAT  = 2'd2;

    localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

    typedef logic signed [WIDE-1:0] wide_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EVX,
        ST_EVY,
        ST_ADX,
        ST_ADY,
        ST_M_NXX,
        ST_M_SXX,
        ST_M_NXY,
        ST_M_SXY,
        ST_M_XXY,
        ST_M_NT,
        ST_M_VAL,
        ST_D_SLOPE,
        ST_D_ICPT,
        ST_D_VAL,
        ST_OUT
    } swlr_state_t;

    // clamp a wide signed value into the 48-bit output range
    function automatic logic [OUT_W-1:0] sat48(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = {{(WIDE-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
        lo = {{(WIDE-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
        if (v > hi)
        begin
            sat48 = SAT_MAX;
        end
        else if (v < lo)
        begin
            sat48 = ~SAT_MAX;
        end
        else
        begin
            sat48 = v[OUT_W-1:0];
        end
    endfunction

endpackage

@@ sv/swlr_if.sv @@
// item channels and configuration write channel
interface swlr_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [23:0] x_value;
    logic signed [23:0] y_value;
    modport source (output valid, kind, x_value, y_value, input ready);
    modport sink   (input valid, kind, x_value, y_value, output ready);
endinterface

interface swlr_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] slope;
    logic signed [47:0] intercept;
    logic signed [47:0] value;
    logic [1:0]         status;
    modport source (output valid, slope, intercept, value, status, input ready);
    modport sink   (input valid, slope, intercept, value, status, output ready);
endinterface

interface swlr_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] window_size;
    modport source (output valid, window_size, input ready);
    modport sink   (input valid, window_size, output ready);
endinterface

@@ sv/swlr_mul.sv @@
// shared signed multiplier, one 8-bit digit of the multiplier per cycle
module swlr_mul
    import swlr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  wide_t a,
    input  wide_t b,
    output logic  done,
    output wide_t prod
);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [WIDE-1:0]   a_reg;
    logic [WIDE-1:0]   b_reg;
    logic [WIDE-1:0]   acc_reg;
    wide_t             prod_reg;
    logic [WIDE-1:0]   a_mag;
    logic [WIDE-1:0]   b_mag;
    logic [WIDE+DIGIT_W-1:0] pp;

    // operand magnitudes and one partial product
    assign a_mag = a[WIDE-1] ? WIDE'(-a) : WIDE'(a);
    assign b_mag = b[WIDE-1] ? WIDE'(-b) : WIDE'(b);
    assign pp    = a_reg * b_reg[DIGIT_W-1:0];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (b_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // shift-and-add datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a_mag;
            b_reg   <= b_mag;
            acc_reg <= '0;
            neg_reg <= a[WIDE-1] ^ b[WIDE-1];
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                prod_reg <= neg_reg ? wide_t'(-acc_reg) : wide_t'(acc_reg);
            end
            else
            begin
                acc_reg <= acc_reg + pp[WIDE-1:0];
                a_reg   <= a_reg << DIGIT_W;
                b_reg   <= b_reg >> DIGIT_W;
            end
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

@@ sv/swlr_div.sv @@
// shared signed divider, restoring, one quotient bit per cycle, rounds half away
module swlr_div
    import swlr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  wide_t num,
    input  wide_t den,
    output logic  done,
    output wide_t quot
);

    localparam int CNT_W = $clog2(WIDE + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [WIDE-1:0]  n_reg;
    logic [WIDE-1:0]  d_reg;
    logic [WIDE-1:0]  r_reg;
    logic [WIDE-1:0]  q_reg;
    wide_t            quot_reg;
    logic [WIDE:0]    r_sh;
    logic [WIDE:0]    r_dbl;
    logic [WIDE-1:0]  q_rnd;
    logic             fit;

    // one restoring step and the final rounding
    assign r_sh  = {r_reg, n_reg[WIDE-1]};
    assign fit   = (r_sh >= {1'b0, d_reg});
    assign r_dbl = {r_reg, 1'b0};
    assign q_rnd = (r_dbl >= {1'b0, d_reg}) ? q_reg + 1'b1 : q_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WIDE);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= num[WIDE-1] ? WIDE'(-num) : WIDE'(num);
            d_reg   <= den[WIDE-1] ? WIDE'(-den) : WIDE'(den);
            r_reg   <= '0;
            q_reg   <= '0;
            neg_reg <= num[WIDE-1] ^ den[WIDE-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                quot_reg <= neg_reg ? wide_t'(-q_rnd) : wide_t'(q_rnd);
            end
            else
            begin
                r_reg <= fit ? WIDE'(r_sh - {1'b0, d_reg}) : r_sh[WIDE-1:0];
                q_reg <= {q_reg[WIDE-2:0], fit};
                n_reg <= n_reg << 1;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ sv/sliding_window_linear_regression_top.sv @@
// sliding window least-squares line fit: ring, running sums, fit sequencer
// sequence: accept, update states ADX and ADY per add (EVX and EVY first when the oldest pair
// is evicted), up to 7 products on the shared digit multiplier, up to 3 quotients on the
// shared divider, then the result register, which can stall on the receiver;
// one item at a time
// rst_n clears window size to 64, sums, count and slot at once; the ring is not cleared
`include "sliding_window_linear_regression_top_assert.svh"

module sliding_window_linear_regression_top
    import swlr_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input logic         clk,
    input logic         rst_n,
    swlr_in_if.sink     req,
    swlr_out_if.source  rsp,
    swlr_cfg_if.sink    cfg
);

    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int CMP_W  = (CNT_W > WS_W) ? CNT_W : WS_W;
    localparam int SX_W   = SAMPLE_BITS + CNT_W;
    localparam int SXY_W  = 2 * SAMPLE_BITS + CNT_W;
    localparam int EXT_SH = IN_W - SAMPLE_BITS;

    swlr_state_t state_reg, state_next;
    logic        launched_reg, launched_next;

    logic [WS_W-1:0]         window_size_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic signed [SX_W-1:0]  sum_x_reg;
    logic signed [SX_W-1:0]  sum_y_reg;
    logic signed [SXY_W-1:0] sum_xx_reg;
    logic signed [SXY_W-1:0] sum_xy_reg;
    logic signed [IN_W-1:0]  newest_reg;

    logic [2:0]             kind_reg;
    logic signed [IN_W-1:0] x_reg;
    logic signed [IN_W-1:0] y_reg;
    logic signed [IN_W-1:0] rd_x_reg;
    logic signed [IN_W-1:0] rd_y_reg;
    logic signed [IN_W-1:0] ring_x_mem [WINDOW_MAX];
    logic signed [IN_W-1:0] ring_y_mem [WINDOW_MAX];

    wide_t t_reg, det_reg, ns_reg, nt_reg, val_reg;
    logic [OUT_W-1:0] slope_reg, icpt_reg, value_reg;
    logic [1:0]       status_reg;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_slope_reg, out_icpt_reg, out_value_reg;
    logic [1:0]       out_status_reg;

    logic                   accept;
    logic                   cfg_acc;
    logic [CNT_W-1:0]       eff_size;
    logic [CMP_W-1:0]       ws_cmp;
    logic [CNT_W-1:0]       slot_inc;
    logic signed [IN_W-1:0] x_shl, y_shl, x_ext, y_ext;
    logic                   rev;
    logic                   flat;
    logic                   no_fit;
    wide_t                  diff;

    logic                   mul_start, mul_done;
    wide_t                  mul_a, mul_b, mul_prod;
    logic                   div_start, div_done;
    wide_t                  div_num, div_den, div_quot;
    logic signed [IN_W-1:0] sm_a, sm_b;
    logic signed [2*IN_W-1:0] sm_p;
    logic                   mem_we;

    // handshakes, a configuration write takes the idle cycle ahead of an item
    assign accept    = req.valid && req.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign req.ready = (state_reg == ST_IDLE) && !cfg.valid;
    assign cfg.ready = (state_reg == ST_IDLE);

    // sample sign extension from the low sample bits
    assign x_shl = req.x_value <<< EXT_SH;
    assign y_shl = req.y_value <<< EXT_SH;
    assign x_ext = x_shl >>> EXT_SH;
    assign y_ext = y_shl >>> EXT_SH;

    // effective window size
    assign ws_cmp = CMP_W'(window_size_reg);
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            eff_size = CNT_W'(1);
        end
        else if (ws_cmp > CMP_W'(WINDOW_MAX))
        begin
            eff_size = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            eff_size = CNT_W'(ws_cmp);
        end
    end

    assign slot_inc = CNT_W'(slot_reg) + 1'b1;
    assign rev      = (kind_reg == KIND_REVERSE);
    assign flat     = rev && (ns_reg == '0);
    assign diff     = t_reg - mul_prod;
    assign no_fit   = diff[WIDE-1] || (diff == '0);
    assign sm_p     = sm_a * sm_b;

    // shared units
    swlr_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    swlr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !cfg_acc)
                begin
                    if (req.kind == KIND_ADD)
                    begin
                        state_next = (count_reg >= eff_size) ? ST_EVX : ST_ADX;
                    end
                    else
                    begin
                        state_next = ST_M_NXX;
                    end
                end
            end
            ST_EVX:   state_next = ST_EVY;
            ST_EVY:   state_next = ST_ADX;
            ST_ADX:   state_next = ST_ADY;
            ST_ADY:   state_next = ST_M_NXX;
            ST_M_NXX: if (launched_reg && mul_done) state_next = ST_M_SXX;
            ST_M_SXX:
            begin
                if (launched_reg && mul_done)
                begin
                    state_next = no_fit ? ST_OUT : ST_M_NXY;
                end
            end
            ST_M_NXY: if (launched_reg && mul_done) state_next = ST_M_SXY;
            ST_M_SXY: if (launched_reg && mul_done) state_next = ST_M_XXY;
            ST_M_XXY: if (launched_reg && mul_done) state_next = ST_M_NT;
            ST_M_NT:
            begin
                if (launched_reg && mul_done)
                begin
                    state_next = flat ? ST_D_SLOPE : ST_M_VAL;
                end
            end
            ST_M_VAL:   if (launched_reg && mul_done) state_next = ST_D_SLOPE;
            ST_D_SLOPE: if (launched_reg && div_done) state_next = ST_D_ICPT;
            ST_D_ICPT:
            begin
                if (launched_reg && div_done)
                begin
                    state_next = flat ? ST_OUT : ST_D_VAL;
                end
            end
            ST_D_VAL: if (launched_reg && div_done) state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // unit launches and operand selection
    always_comb
    begin
        mul_start     = 1'b0;
        div_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_num       = '0;
        div_den       = det_reg;
        sm_a          = x_reg;
        sm_b          = y_reg;
        mem_we        = 1'b0;
        launched_next = 1'b0;
        case (state_reg)
            ST_EVX:
            begin
                sm_a = rd_x_reg;
                sm_b = rd_x_reg;
            end
            ST_EVY:
            begin
                sm_a = rd_x_reg;
                sm_b = rd_y_reg;
            end
            ST_ADX:
            begin
                sm_a   = x_reg;
                sm_b   = x_reg;
                mem_we = 1'b1;
            end
            ST_ADY:
            begin
                sm_a = x_reg;
                sm_b = y_reg;
            end
            ST_M_NXX, ST_M_SXX, ST_M_NXY, ST_M_SXY, ST_M_XXY, ST_M_NT, ST_M_VAL:
            begin
                mul_start     = !launched_reg;
                launched_next = !(launched_reg && mul_done);
                case (state_reg)
                    ST_M_NXX:
                    begin
                        mul_a = wide_t'($signed({1'b0, count_reg}));
                        mul_b = wide_t'(sum_xx_reg);
                    end
                    ST_M_SXX:
                    begin
                        mul_a = wide_t'(sum_x_reg);
                        mul_b = wide_t'(sum_x_reg);
                    end
                    ST_M_NXY:
                    begin
                        mul_a = wide_t'($signed({1'b0, count_reg}));
                        mul_b = wide_t'(sum_xy_reg);
                    end
                    ST_M_SXY:
                    begin
                        mul_a = wide_t'(sum_x_reg);
                        mul_b = wide_t'(sum_y_reg);
                    end
                    ST_M_XXY:
                    begin
                        mul_a = wide_t'(sum_xx_reg);
                        mul_b = wide_t'(sum_y_reg);
                    end
                    ST_M_NT:
                    begin
                        mul_a = wide_t'(sum_x_reg);
                        mul_b = wide_t'(sum_xy_reg);
                    end
                    default:
                    begin
                        // value numerator: det*y for reverse, ns*x for forecast, ns*newest otherwise
                        if (rev)
                        begin
                            mul_a = det_reg;
                            mul_b = wide_t'(y_reg);
                        end
                        else
                        begin
                            mul_a = ns_reg;
                            mul_b = (kind_reg == KIND_FORECAST) ? wide_t'(x_reg)
                                                                : wide_t'(newest_reg);
                        end
                    end
                endcase
            end
            ST_D_SLOPE:
            begin
                div_start     = !launched_reg;
                launched_next = !(launched_reg && div_done);
                div_num       = ns_reg <<< SLOPE_FRAC;
            end
            ST_D_ICPT:
            begin
                div_start     = !launched_reg;
                launched_next = !(launched_reg && div_done);
                div_num       = nt_reg;
            end
            ST_D_VAL:
            begin
                div_start     = !launched_reg;
                launched_next = !(launched_reg && div_done);
                div_num       = val_reg;
                div_den       = rev ? ns_reg : det_reg;
            end
            default:
            begin
                launched_next = 1'b0;
            end
        endcase
    end

    // control state, window and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            launched_reg    <= 1'b0;
            window_size_reg <= WINDOW_RESET;
            count_reg       <= '0;
            slot_reg        <= '0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            sum_xx_reg      <= '0;
            sum_xy_reg      <= '0;
            newest_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            if (cfg_acc || (accept && (req.kind == KIND_CLEAR)))
            begin
                if (cfg_acc)
                begin
                    window_size_reg <= cfg.window_size;
                end
                count_reg  <= '0;
                slot_reg   <= '0;
                sum_x_reg  <= '0;
                sum_y_reg  <= '0;
                sum_xx_reg <= '0;
                sum_xy_reg <= '0;
                newest_reg <= '0;
            end
            else
            begin
                case (state_reg)
                    ST_EVX:
                    begin
                        sum_x_reg  <= sum_x_reg - SX_W'(rd_x_reg);
                        sum_y_reg  <= sum_y_reg - SX_W'(rd_y_reg);
                        sum_xx_reg <= sum_xx_reg - SXY_W'(sm_p);
                        count_reg  <= count_reg - 1'b1;
                    end
                    ST_EVY:
                    begin
                        sum_xy_reg <= sum_xy_reg - SXY_W'(sm_p);
                    end
                    ST_ADX:
                    begin
                        sum_x_reg  <= sum_x_reg + SX_W'(x_reg);
                        sum_y_reg  <= sum_y_reg + SX_W'(y_reg);
                        sum_xx_reg <= sum_xx_reg + SXY_W'(sm_p);
                        count_reg  <= count_reg + 1'b1;
                        newest_reg <= x_reg;
                        slot_reg   <= (slot_inc >= eff_size) ? '0 : slot_inc[SLOT_W-1:0];
                    end
                    ST_ADY:
                    begin
                        sum_xy_reg <= sum_xy_reg + SXY_W'(sm_p);
                    end
                    default:
                    begin
                    end
                endcase
            end
            // output register
            if ((state_reg == ST_OUT) && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sample ring
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_x_mem[slot_reg] <= x_reg;
            ring_y_mem[slot_reg] <= y_reg;
        end
        if (accept)
        begin
            rd_x_reg <= ring_x_mem[slot_reg];
            rd_y_reg <= ring_y_mem[slot_reg];
        end
    end

    // item latch, fit terms and results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= req.kind;
            x_reg    <= x_ext;
            y_reg    <= y_ext;
        end
        if (launched_reg && mul_done)
        begin
            case (state_reg)
                ST_M_NXX, ST_M_NXY, ST_M_XXY: t_reg <= mul_prod;
                ST_M_SXX:
                begin
                    det_reg <= diff;
                    if (no_fit)
                    begin
                        slope_reg  <= '0;
                        icpt_reg   <= '0;
                        value_reg  <= rev ? SAT_MAX : '0;
                        status_reg <= STATUS_NOFIT;
                    end
                end
                ST_M_SXY: ns_reg <= diff;
                ST_M_NT:
                begin
                    nt_reg     <= diff;
                    status_reg <= flat ? STATUS_FLAT : STATUS_FIT;
                    value_reg  <= SAT_MAX;
                end
                ST_M_VAL: val_reg <= rev ? (mul_prod - nt_reg) : (mul_prod + nt_reg);
                default:
                begin
                end
            endcase
        end
        if (launched_reg && div_done)
        begin
            case (state_reg)
                ST_D_SLOPE: slope_reg <= sat48(div_quot);
                ST_D_ICPT:  icpt_reg  <= sat48(div_quot);
                ST_D_VAL:   value_reg <= sat48(div_quot);
                default:
                begin
                end
            endcase
        end
        if ((state_reg == ST_OUT) && (!out_valid_reg || rsp.ready))
        begin
            out_slope_reg  <= slope_reg;
            out_icpt_reg   <= icpt_reg;
            out_value_reg  <= value_reg;
            out_status_reg <= status_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.slope     = out_slope_reg;
    assign rsp.intercept = out_icpt_reg;
    assign rsp.value     = out_value_reg;
    assign rsp.status    = out_status_reg;

    // checks
    `SWLR_ASSERT_IMP(a_fill_in_window, 1'b1, count_reg <= eff_size, "fill count above window")
    `SWLR_ASSERT_IMP(a_slot_in_window, 1'b1, CNT_W'(slot_reg) < eff_size, "slot outside window")
    `SWLR_ASSERT_NXT(a_busy_after_item, req.valid && req.ready, !req.ready, "ready after item")
    `SWLR_ASSERT_NXT(a_result_shown, (state_reg == ST_OUT) && (!rsp.valid || rsp.ready), rsp.valid, "result lost")

endmodule

@@ test/tb.sv @@
// testbench for the sliding window least-squares line fit
module tb;
    import swlr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] acc_t;

    typedef struct packed {
        logic [47:0] slope;
        logic [47:0] intercept;
        logic [47:0] value;
        logic [1:0]  status;
    } fit_result_t;

    // line fit predictor and queue of predicted results
    class regression_scoreboard;
        logic signed [23:0] ring_x[64];
        logic signed [23:0] ring_y[64];
        int unsigned        fill;
        int unsigned        slot;
        int unsigned        win;
        longint             sx, sy, sxx, sxy, newest;
        fit_result_t        pending[$];
        int                 errors;
        int                 checked;

        function new();
            errors = 0;
            checked = 0;
            win = 32'(WINDOW_RESET);
            clear_window();
        endfunction

        function void clear_window();
            foreach (ring_x[i])
            begin
                ring_x[i] = '0;
                ring_y[i] = '0;
            end
            fill = 0;
            slot = 0;
            sx = 0;
            sy = 0;
            sxx = 0;
            sxy = 0;
            newest = 0;
        endfunction

        function void set_window(logic [6:0] v);
            win = 32'(v);
            clear_window();
        endfunction

        // division rounded to nearest, ties away from zero
        function acc_t round_div(acc_t n, acc_t d);
            acc_t an, ad, q, r;
            an = (n < 0) ? -n : n;
            ad = (d < 0) ? -d : d;
            q = an / ad;
            r = an - q * ad;
            if (r >= ad - r)
            begin
                q = q + 1;
            end
            return ((n < 0) != (d < 0)) ? -q : q;
        endfunction

        function logic [47:0] clamp48(acc_t v);
            acc_t top, bot;
            top = (acc_t'(1) <<< 47) - 1;
            bot = -(acc_t'(1) <<< 47);
            if (v > top)
            begin
                return SAT_MAX;
            end
            if (v < bot)
            begin
                return ~SAT_MAX;
            end
            return v[47:0];
        endfunction

        // update the window for one accepted item and predict its result
        function void note_item(logic [2:0] kind, logic signed [23:0] x, logic signed [23:0] y);
            int unsigned size, s;
            longint      px, ox, oy, xl, yl;
            acc_t        n, det, ns, nt, num;
            fit_result_t res;
            size = (win == 0) ? 1 : ((win > 64) ? 64 : win);
            xl = longint'(x);
            yl = longint'(y);
            px = newest;
            if (kind == KIND_ADD)
            begin
                s = slot % 64;
                if (fill >= size)
                begin
                    ox = longint'(ring_x[s]);
                    oy = longint'(ring_y[s]);
                    fill--;
                    sx -= ox;
                    sy -= oy;
                    sxx -= ox * ox;
                    sxy -= ox * oy;
                end
                fill++;
                sx += xl;
                sy += yl;
                sxx += xl * xl;
                sxy += xl * yl;
                ring_x[s] = x;
                ring_y[s] = y;
                newest = xl;
                slot = (s + 1) % size;
                px = xl;
            end
            else if (kind == KIND_CLEAR)
            begin
                clear_window();
                px = 0;
            end
            else if (kind == KIND_FORECAST)
            begin
                px = xl;
            end
            res = '0;
            n = acc_t'(fill);
            det = n * acc_t'(sxx) - acc_t'(sx) * acc_t'(sx);
            if (det <= 0)
            begin
                res.status = STATUS_NOFIT;
                res.value = (kind == KIND_REVERSE) ? SAT_MAX : '0;
            end
            else
            begin
                ns = n * acc_t'(sxy) - acc_t'(sx) * acc_t'(sy);
                nt = acc_t'(sxx) * acc_t'(sy) - acc_t'(sx) * acc_t'(sxy);
                res.slope = clamp48(round_div(ns * acc_t'(16777216), det));
                res.intercept = clamp48(round_div(nt, det));
                res.status = STATUS_FIT;
                if (kind == KIND_REVERSE)
                begin
                    if (ns == 0)
                    begin
                        res.value = SAT_MAX;
                        res.status = STATUS_FLAT;
                    end
                    else
                    begin
                        num = det * acc_t'(yl) - nt;
                        res.value = clamp48(round_div(num, ns));
                    end
                end
                else
                begin
                    num = ns * acc_t'(px) + nt;
                    res.value = clamp48(round_div(num, det));
                end
            end
            pending.push_back(res);
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(fit_result_t got);
            fit_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.slope !== want.slope)
            begin
                $display("%0t: slope expected %h actual %h", $realtime, want.slope, got.slope);
                errors++;
            end
            if (got.intercept !== want.intercept)
            begin
                $display("%0t: intercept expected %h actual %h", $realtime,
                         want.intercept, got.intercept);
                errors++;
            end
            if (got.value !== want.value)
            begin
                $display("%0t: value expected %h actual %h", $realtime, want.value, got.value);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %h actual %h", $realtime,
                         want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    swlr_in_if  req_ch();
    swlr_out_if rsp_ch();
    swlr_cfg_if cfg_ch();

    sliding_window_linear_regression_top i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    regression_scoreboard fit_board;
    int                   burst_left;
    bit                   long_hold_done;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // item monitors at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            fit_board.note_item(req_ch.kind, req_ch.x_value, req_ch.y_value);
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            fit_board.check_result({rsp_ch.slope, rsp_ch.intercept, rsp_ch.value,
                                    rsp_ch.status});
        end
    end

    // receiver stall pattern, with one long hold-off
    initial
    begin : receiver
        int cyc;
        int mode;
        int hold;
        cyc = 0;
        mode = 0;
        hold = 0;
        long_hold_done = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 300 == 0)
            begin
                mode = $urandom_range(0, 3);
            end
            if (!long_hold_done && fit_board.checked >= 200)
            begin
                long_hold_done = 1;
                hold = 4000;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready = 1'b0;
            end
            else
            begin
                case (mode)
                    0: rsp_ch.ready = 1'b1;
                    1: rsp_ch.ready = ($urandom_range(0, 3) != 0);
                    2: rsp_ch.ready = ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready = ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    // offer one item, in bursts separated by random gaps
    task automatic send_item(logic [2:0] kind, logic [23:0] x, logic [23:0] y);
        int gap;
        if (burst_left == 0)
        begin
            req_ch.valid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        req_ch.valid = 1'b1;
        req_ch.kind = kind;
        req_ch.x_value = x;
        req_ch.y_value = y;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        @(negedge clk);
        if (burst_left == 0)
        begin
            req_ch.valid = 1'b0;
        end
    endtask

    // wait until every predicted result has arrived and the block has settled
    task automatic drain();
        req_ch.valid = 1'b0;
        burst_left = 0;
        while (fit_board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (400) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_window(logic [6:0] v);
        cfg_ch.valid = 1'b1;
        cfg_ch.window_size = v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        fit_board.set_window(v);
    endtask

    // one random item, mostly sample adds with shaped content
    task automatic random_item();
        int          r;
        int          m;
        int          xi;
        logic [23:0] x;
        logic [23:0] y;
        r = $urandom_range(0, 99);
        m = $urandom_range(0, 4);
        x = 24'($urandom);
        y = 24'($urandom);
        if (m == 1)
        begin
            xi = ($urandom_range(0, 200) - 100) * 4096;
            x = 24'(xi);
            y = 24'(2 * xi + 4096 + int'($urandom_range(0, 3)));
        end
        else if (m == 2)
        begin
            x = 24'(($urandom_range(0, 8) - 4) * 4096);
            y = 24'(($urandom_range(0, 8) - 4) * 4096);
        end
        else if (m == 3)
        begin
            y = 24'h001000;
        end
        if (r < 65)
        begin
            send_item(KIND_ADD, x, y);
        end
        else if (r < 75)
        begin
            send_item(KIND_FORECAST, x, y);
        end
        else if (r < 85)
        begin
            send_item(KIND_REVERSE, x, y);
        end
        else if (r < 92)
        begin
            send_item(KIND_FIT, x, y);
        end
        else if (r < 95)
        begin
            send_item(KIND_CLEAR, x, y);
        end
        else
        begin
            send_item(3'($urandom_range(5, 7)), x, y);
        end
    endtask

    // time limit
    initial
    begin
        #48_000_000;
        $display("sliding_window_linear_regression_top: mismatch");
        $finish;
    end

    // main sequence
    initial
    begin : stimulus
        logic [6:0] sizes[7];
        fit_board = new();
        burst_left = 0;
        sizes = '{7'd1, 7'd2, 7'd127, 7'd0, 7'd5, 7'd64, 7'd0};
        sizes[6] = 7'($urandom_range(3, 63));
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_FIT;
        req_ch.x_value = '0;
        req_ch.y_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.window_size = WINDOW_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty window, extremes, flat line, repeated x and unused kinds
        send_item(KIND_FIT, 24'h0, 24'h0);
        send_item(KIND_REVERSE, 24'h001000, 24'h001000);
        send_item(KIND_FORECAST, 24'h7FFFFF, 24'h0);
        send_item(KIND_ADD, 24'h800000, 24'h7FFFFF);
        send_item(KIND_ADD, 24'h800000, 24'h800000);
        send_item(KIND_REVERSE, 24'h0, 24'h001000);
        send_item(KIND_ADD, 24'h7FFFFF, 24'h800000);
        send_item(KIND_FORECAST, 24'h7FFFFF, 24'h0);
        send_item(KIND_FORECAST, 24'h800000, 24'hFFFFFF);
        send_item(KIND_REVERSE, 24'h0, 24'h7FFFFF);
        send_item(KIND_FIT, 24'h0, 24'h0);
        send_item(3'd5, 24'h123456, 24'h654321);
        send_item(3'd6, 24'h0, 24'h0);
        send_item(3'd7, 24'hFFFFFF, 24'hFFFFFF);
        send_item(KIND_CLEAR, 24'h7FFFFF, 24'h7FFFFF);
        send_item(KIND_ADD, 24'h001000, 24'h003000);
        send_item(KIND_ADD, 24'h002000, 24'h003000);
        send_item(KIND_ADD, 24'hFFF000, 24'h003000);
        send_item(KIND_REVERSE, 24'h0, 24'h003000);
        send_item(KIND_FORECAST, 24'h7FFFFF, 24'h0);
        send_item(KIND_CLEAR, 24'h0, 24'h0);
        send_item(KIND_ADD, 24'h7FFFFF, 24'h7FFFFF);
        send_item(KIND_ADD, 24'h7FFFFF, 24'h000000);
        send_item(KIND_REVERSE, 24'h0, 24'h0);

        repeat (240) random_item();
        foreach (sizes[p])
        begin
            drain();
            write_window(sizes[p]);
            repeat (210) random_item();
        end

        drain();
        if (fit_board.errors == 0)
        begin
            $display("sliding_window_linear_regression_top: match");
        end
        else
        begin
            $display("sliding_window_linear_regression_top: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/swlr_pkg.sv
sv/swlr_if.sv
sv/swlr_mul.sv
sv/swlr_div.sv
sv/sliding_window_linear_regression_top.sv
test/tb.sv
